// File: rtl/core/tkd_pkg.sv
`default_nettype none

package tkd_pkg;

   // Field widths
   localparam int KEY_W   = 9;
   localparam int COL_W   = 10;
   localparam int LINE_W  = 16;
   localparam int BYTE_W  = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Depth of the queue between parser and cursor unit
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_COLS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LINE_COUNT  = 2'd2;

   // Register reset values
   localparam logic [COL_W-1:0]  ROWS_RESET  = 10'd24;
   localparam logic [COL_W-1:0]  COLS_RESET  = 10'd80;
   localparam logic [LINE_W-1:0] COUNT_RESET = 16'd0;

   // Terminal bytes
   localparam logic [BYTE_W-1:0] CH_ESC     = 8'h1b;
   localparam logic [BYTE_W-1:0] CH_QUIT    = 8'h11;
   localparam logic [BYTE_W-1:0] CH_BRACKET = "[";
   localparam logic [BYTE_W-1:0] CH_SS3     = "O";
   localparam logic [BYTE_W-1:0] CH_TILDE   = "~";

   // Key codes
   localparam logic [KEY_W-1:0] K_ESC   = 9'd27;
   localparam logic [KEY_W-1:0] K_QUIT  = 9'd17;
   localparam logic [KEY_W-1:0] K_LEFT  = 9'd256;
   localparam logic [KEY_W-1:0] K_RIGHT = 9'd257;
   localparam logic [KEY_W-1:0] K_UP    = 9'd258;
   localparam logic [KEY_W-1:0] K_DOWN  = 9'd259;
   localparam logic [KEY_W-1:0] K_DEL   = 9'd260;
   localparam logic [KEY_W-1:0] K_HOME  = 9'd261;
   localparam logic [KEY_W-1:0] K_END   = 9'd262;
   localparam logic [KEY_W-1:0] K_PGUP  = 9'd263;
   localparam logic [KEY_W-1:0] K_PGDN  = 9'd264;

   // One decoded key moving between parser, queue and cursor unit
   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
   } key_beat_type;

endpackage

`default_nettype wire

// File: rtl/core/terminal_key_decoder_cursor_core.sv
// Terminal key decoder with cursor tracking.
//
// Input channel (req_*): one beat per terminal byte, or with req_opcode high a
// beat meaning the read wait expired. ESC sequences are parsed in the front
// stage; plain bytes, decoded keys and ESC on timeout or unknown sequences go
// into a two-entry queue. The cursor stage pops keys, moves and clamps the
// cursor, scrolls the row offset and presents one result beat on rsp_*.
// Beats that only advance the parser (ESC, sequence bytes, idle timeouts)
// produce no result.
// Config channel (csr_*): always ready; write only while the block is idle.
// A decoded key passes the queue and then the output register before rsp_valid
// rises; while the output is stalled, keys wait in the queue.
// Throughput: one input beat per cycle while the receiver takes each result,
// set by the cursor update in the back stage. When the receiver stalls, the output
// register holds its beat and the queue absorbs up to two more keys before req_ready drops.
// Reset clears the parser, queue, cursor and offset, and loads screen_rows 24,
// screen_cols 80, line_count 0. No clearing pass is needed.
`default_nettype none

module terminal_key_decoder_cursor_core import tkd_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_opcode,
   input  wire logic [BYTE_W-1:0]     req_in_byte,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [KEY_W-1:0]           rsp_key_code,
   output logic [COL_W-1:0]           rsp_cursor_col,
   output logic [LINE_W-1:0]          rsp_cursor_row,
   output logic [LINE_W-1:0]          rsp_row_offset,
   output logic                       rsp_quit,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   key_beat_type push, pop;
   logic         push_ready, pop_ready;

   tkd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_opcode  (req_opcode),
      .req_in_byte (req_in_byte),
      .push_ready  (push_ready),
      .push        (push)
   );

   tkd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_ready  (pop_ready)
   );

   tkd_cursor u_cursor (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .pop            (pop),
      .pop_ready      (pop_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_key_code   (rsp_key_code),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_row_offset (rsp_row_offset),
      .rsp_quit       (rsp_quit)
   );

endmodule

`default_nettype wire

// File: rtl/core/tkd_front.sv
`default_nettype none

module tkd_front import tkd_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_opcode,
   input  wire logic [BYTE_W-1:0] req_in_byte,
   input  wire logic              push_ready,
   output key_beat_type           push
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_ESC,
      PH_SEQ1,
      PH_SEQ2
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] first_ff, first_in;
   logic [BYTE_W-1:0] second_ff, second_in;
   logic              accept;
   logic              is_digit;

   function automatic logic [KEY_W-1:0] decode_bracket(input logic [BYTE_W-1:0] b);
      logic [KEY_W-1:0] k;
      unique case (b)
         "A":     k = K_UP;
         "B":     k = K_DOWN;
         "C":     k = K_RIGHT;
         "D":     k = K_LEFT;
         "H":     k = K_HOME;
         "F":     k = K_END;
         default: k = K_ESC;
      endcase
      return k;
   endfunction

   function automatic logic [KEY_W-1:0] decode_tilde(input logic [BYTE_W-1:0] d);
      logic [KEY_W-1:0] k;
      unique case (d) inside
         "1", "7": k = K_HOME;
         "3":      k = K_DEL;
         "4", "8": k = K_END;
         "5":      k = K_PGUP;
         "6":      k = K_PGDN;
         default:  k = K_ESC;
      endcase
      return k;
   endfunction

   assign req_ready = push_ready;
   assign accept    = req_valid && push_ready;
   assign is_digit  = (req_in_byte >= "0") && (req_in_byte <= "9");

   // Classify the beat against the parse phase
   always_comb begin
      phase_in   = phase_ff;
      first_in   = first_ff;
      second_in  = second_ff;
      push.valid = 1'b0;
      push.key   = K_ESC;
      if (accept) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (!req_opcode) begin
                  if (req_in_byte == CH_ESC) begin
                     phase_in = PH_ESC;
                  end else begin
                     push.valid = 1'b1;
                     push.key   = {1'b0, req_in_byte};
                  end
               end
            end
            PH_ESC: begin
               if (req_opcode) begin
                  phase_in   = PH_IDLE;
                  push.valid = 1'b1;
               end else begin
                  first_in = req_in_byte;
                  phase_in = PH_SEQ1;
               end
            end
            PH_SEQ1: begin
               if (req_opcode) begin
                  phase_in   = PH_IDLE;
                  push.valid = 1'b1;
               end else begin
                  second_in = req_in_byte;
                  if (first_ff == CH_BRACKET && is_digit) begin
                     phase_in = PH_SEQ2;
                  end else begin
                     phase_in   = PH_IDLE;
                     push.valid = 1'b1;
                     if (first_ff == CH_BRACKET) begin
                        push.key = decode_bracket(req_in_byte);
                     end else if (first_ff == CH_SS3 && req_in_byte == "H") begin
                        push.key = K_HOME;
                     end else if (first_ff == CH_SS3 && req_in_byte == "F") begin
                        push.key = K_END;
                     end
                  end
               end
            end
            PH_SEQ2: begin
               phase_in   = PH_IDLE;
               push.valid = 1'b1;
               if (!req_opcode && req_in_byte == CH_TILDE) begin
                  push.key = decode_tilde(second_ff);
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   // Hold parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         first_ff  <= '0;
         second_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/tkd_queue.sv
`default_nettype none

module tkd_queue import tkd_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire key_beat_type push,
   output logic              push_ready,
   output key_beat_type      pop,
   input  wire logic         pop_ready
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   logic [KEY_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop.valid  = (count_ff != '0);
   assign pop.key    = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop.valid && pop_ready;

   // Advance pointers and the fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.key;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/tkd_cursor.sv
`default_nettype none

module tkd_cursor import tkd_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire key_beat_type          pop,
   output logic                       pop_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [KEY_W-1:0]           rsp_key_code,
   output logic [COL_W-1:0]           rsp_cursor_col,
   output logic [LINE_W-1:0]          rsp_cursor_row,
   output logic [LINE_W-1:0]          rsp_row_offset,
   output logic                       rsp_quit
);

   logic [COL_W-1:0]  rows_ff, cols_ff;
   logic [LINE_W-1:0] count_ff;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [LINE_W-1:0] top_ff, top_in;
   logic              rsp_valid_ff;
   logic [KEY_W-1:0]  key_ff;
   logic              quit_ff;

   logic              take;
   logic [COL_W:0]    col_inc;
   logic [LINE_W:0]   pg_sum;
   logic [COL_W-1:0]  rows_eff;
   logic [LINE_W-1:0] top_mid;
   logic [LINE_W:0]   top_lim;

   assign csr_ready = 1'b1;
   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign take      = pop.valid && pop_ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= ROWS_RESET;
         cols_ff  <= COLS_RESET;
         count_ff <= COUNT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_SCREEN_ROWS: rows_ff  <= csr_data[COL_W-1:0];
            REG_SCREEN_COLS: cols_ff  <= csr_data[COL_W-1:0];
            REG_LINE_COUNT:  count_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign col_inc = {1'b0, col_ff} + (COL_W+1)'(1);
   assign pg_sum  = {1'b0, line_ff} + {{(LINE_W-COL_W+1){1'b0}}, rows_ff};

   // Move the cursor for the key
   always_comb begin
      col_in  = col_ff;
      line_in = line_ff;
      case (pop.key)
         K_LEFT:  if (col_ff != '0) col_in = col_ff - COL_W'(1);
         K_RIGHT: if (col_inc < {1'b0, cols_ff}) col_in = col_inc[COL_W-1:0];
         K_UP:    if (line_ff != '0) line_in = line_ff - LINE_W'(1);
         K_DOWN:  if (line_ff < count_ff) line_in = line_ff + LINE_W'(1);
         K_HOME:  col_in = '0;
         K_END:   col_in = (cols_ff != '0) ? cols_ff - COL_W'(1) : '0;
         K_PGUP: begin
            if (line_ff >= {{(LINE_W-COL_W){1'b0}}, rows_ff}) begin
               line_in = line_ff - {{(LINE_W-COL_W){1'b0}}, rows_ff};
            end else begin
               line_in = '0;
            end
         end
         K_PGDN: begin
            if (line_ff < count_ff) begin
               line_in = (pg_sum > {1'b0, count_ff}) ? count_ff : pg_sum[LINE_W-1:0];
            end
         end
         default: ;
      endcase
   end

   // Scroll so the cursor line stays on screen
   always_comb begin
      rows_eff = (rows_ff == '0) ? COL_W'(1) : rows_ff;
      top_mid  = (line_in < top_ff) ? line_in : top_ff;
      top_lim  = {1'b0, top_mid} + {{(LINE_W-COL_W+1){1'b0}}, rows_eff};
      top_in   = top_mid;
      if ({1'b0, line_in} >= top_lim) begin
         top_in = line_in - {{(LINE_W-COL_W){1'b0}}, rows_eff} + LINE_W'(1);
      end
   end

   // Cursor state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         line_ff      <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            col_ff  <= col_in;
            line_ff <= line_in;
            top_ff  <= top_in;
         end
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         key_ff  <= pop.key;
         quit_ff <= (pop.key == K_QUIT);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_key_code   = key_ff;
   assign rsp_cursor_col = col_ff;
   assign rsp_cursor_row = line_ff;
   assign rsp_row_offset = top_ff;
   assign rsp_quit       = quit_ff;

endmodule

`default_nettype wire

// File: rtl/core/tkd_checker.sv
`default_nettype none

module tkd_checker import tkd_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [KEY_W-1:0]  rsp_key_code,
   input wire logic [LINE_W-1:0] rsp_cursor_row,
   input wire logic [LINE_W-1:0] rsp_row_offset,
   input wire logic              rsp_quit
);

   // A stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_key_code))
      else $error("stalled result beat changed");

   // No result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Cursor line is never above the first visible line
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cursor_row >= rsp_row_offset)
      else $error("cursor scrolled off the top");

   // Quit flags exactly the Ctrl-Q key
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_quit == (rsp_key_code == K_QUIT))
      else $error("quit flag mismatch");

   // Key codes stay in the defined range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_key_code <= K_PGDN)
      else $error("key code out of range");

endmodule

bind terminal_key_decoder_cursor_core tkd_checker u_tkd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_key_code   (rsp_key_code),
   .rsp_cursor_row (rsp_cursor_row),
   .rsp_row_offset (rsp_row_offset),
   .rsp_quit       (rsp_quit)
);

`default_nettype wire
